// ===== hw/rtl/cka_pkg.sv =====
package cka_pkg;

    localparam int KEY_DEPTH = 64;
    localparam int IDX_W     = $clog2(KEY_DEPTH);
    localparam int SUM_W     = IDX_W + 1;

    localparam int SYM_W     = 16;
    localparam int ACT_W     = 2;
    localparam int ENTRY_W   = 6;
    localparam int LEN_W     = 7;
    localparam int IN_DATA_W = 24;
    localparam int OUT_DATA_W = 16;

    localparam logic [LEN_W-1:0] KEY_LEN_RESET = LEN_W'(64);

    localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ENC     = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DEC     = 2'd2;
    localparam logic [ACT_W-1:0] ACT_RESTART = 2'd3;

    // Record that ripples down the row of cells, one cell per cycle.
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] pos;
        logic [SYM_W-1:0] data;
    } cka_rec_t;

    // Controls broadcast to every cell during a pass.
    typedef struct packed {
        logic             search;
        logic             readout;
        logic [SYM_W-1:0] sym;
        logic [IDX_W-1:0] target;
        logic [SUM_W-1:0] len;
    } cka_bcast_t;

    typedef struct packed {
        logic               wr_en;
        logic [ENTRY_W-1:0] wr_idx;
        logic [SYM_W-1:0]   wr_data;
    } cka_wr_t;

    // A length of zero acts as one, and anything above the depth as the depth.
    function automatic logic [SUM_W-1:0] active_len(input logic [LEN_W-1:0] key_length);
        logic [SUM_W-1:0] n;
        if (key_length == '0)
        begin
            n = SUM_W'(1);
        end
        else if (int'(key_length) > KEY_DEPTH)
        begin
            n = SUM_W'(KEY_DEPTH);
        end
        else
        begin
            n = SUM_W'(key_length);
        end
        return n;
    endfunction

endpackage

// ===== hw/rtl/chained_key_alphabet_cipher.sv =====
// Channel   Direction  Beat content
// s_axis    in         tuser: action; tdata: symbol, entry_index
// m_axis    out        tdata: out_symbol; tuser: symbol_found
// cfg       in         cfg_data: key_length
//
// Load and restart items are taken without a pass through the cells. Encrypt and a
// matching decrypt run a search pass and a readout pass, each rippling through the
// row of key cells at one cell per cycle, and the input reopens together with the
// result beat. A decrypt that finds no match frees the input after the search pass,
// with no result. After key_length is lowered, a stale chain is brought back into
// range by repeated subtraction. Reset clears the chain and the output valid flag
// and sets key_length to 64; key cells are not cleared. A result waits in the
// output register while the next item is worked on; the block stalls only when a
// second result is ready and the first has not been taken.
module chained_key_alphabet_cipher (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [cka_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // [15:0] symbol, [21:16] entry_index
    input  logic [cka_pkg::ACT_W-1:0]       s_axis_tuser,  // [1:0] action
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [cka_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // [15:0] out_symbol
    output logic [0:0]                      m_axis_tuser,  // [0] symbol_found
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cka_pkg::LEN_W-1:0]       cfg_data
);
    import cka_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_SEARCH = 3'd2;
    localparam logic [2:0] ST_CALC   = 3'd3;
    localparam logic [2:0] ST_READ   = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    logic [2:0]       state_reg,   state_next;
    logic [IDX_W-1:0] cnt_reg,     cnt_next;
    logic [IDX_W-1:0] chain_reg,   chain_next;
    logic [IDX_W-1:0] target_reg,  target_next;
    logic             found_reg,   found_next;
    logic [ACT_W-1:0] action_reg,  action_next;
    logic [SYM_W-1:0] sym_reg,     sym_next;
    logic [LEN_W-1:0] key_len_reg, key_len_next;
    logic             out_valid_reg, out_valid_next;
    logic [SYM_W-1:0] out_data_reg,  out_data_next;
    logic             out_found_reg, out_found_next;

    logic             in_beat;
    logic [SUM_W-1:0] len;
    logic [SUM_W-1:0] enc_sum;
    logic [SUM_W-1:0] enc_chain;
    logic [SUM_W-1:0] dec_target;
    logic             pass_done;

    cka_wr_t    wr;
    cka_bcast_t bc;
    cka_rec_t   chain_rec [KEY_DEPTH+1];
    cka_rec_t   tail;

    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign len           = active_len(key_len_reg);
    assign pass_done     = (cnt_reg == IDX_W'(KEY_DEPTH - 1));

    assign wr.wr_en   = in_beat && (s_axis_tuser == ACT_LOAD);
    assign wr.wr_idx  = s_axis_tdata[SYM_W +: ENTRY_W];
    assign wr.wr_data = s_axis_tdata[SYM_W-1:0];

    assign bc.search  = (state_reg == ST_SEARCH);
    assign bc.readout = (state_reg == ST_READ) || (state_reg == ST_EMIT);
    assign bc.sym     = sym_reg;
    assign bc.target  = target_reg;
    assign bc.len     = len;

    assign chain_rec[0] = '{hit: 1'b0, pos: '0, data: '0};

    genvar gi;
    generate
        for (gi = 0; gi < KEY_DEPTH; gi++)
        begin : g_cell
            cka_cell u_cell (
                .clk      (clk),
                .cell_idx (IDX_W'(gi)),
                .wr       (wr),
                .bc       (bc),
                .rec_in   (chain_rec[gi]),
                .rec_out  (chain_rec[gi+1])
            );
        end
    endgenerate

    assign tail = chain_rec[KEY_DEPTH];

    // Both operands are below the length, so one subtraction brings the sum back.
    assign enc_sum   = SUM_W'(chain_reg) + SUM_W'(tail.pos);
    assign enc_chain = (enc_sum >= len) ? (enc_sum - len) : enc_sum;
    assign dec_target = (tail.pos >= chain_reg)
                      ? (SUM_W'(tail.pos) - SUM_W'(chain_reg))
                      : (SUM_W'(tail.pos) + len - SUM_W'(chain_reg));

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        chain_next     = chain_reg;
        target_next    = target_reg;
        found_next     = found_reg;
        action_next    = action_reg;
        sym_next       = sym_reg;
        key_len_next   = key_len_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_found_next = out_found_reg;

        if (cfg_valid && cfg_ready)
        begin
            key_len_next = cfg_data;
        end

        if (m_axis_tvalid && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    action_next = s_axis_tuser;
                    sym_next    = s_axis_tdata[SYM_W-1:0];
                    if ((s_axis_tuser == ACT_LOAD) || (s_axis_tuser == ACT_RESTART))
                    begin
                        chain_next = '0;
                    end
                    else
                    begin
                        // The chain as it stood is kept here until the search
                        // is over, since a decrypt miss must leave it untouched.
                        target_next = chain_reg;
                        state_next  = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                // The chain may be left over from a longer key; bring it into range.
                if (SUM_W'(chain_reg) >= len)
                begin
                    chain_next = IDX_W'(SUM_W'(chain_reg) - len);
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                cnt_next = cnt_reg + IDX_W'(1);
                if (pass_done)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cnt_next = '0;
                if (action_reg == ACT_ENC)
                begin
                    found_next = tail.hit;
                    if (tail.hit)
                    begin
                        chain_next  = IDX_W'(enc_chain);
                        target_next = IDX_W'(enc_chain);
                    end
                    else
                    begin
                        target_next = chain_reg;
                    end
                    state_next = ST_READ;
                end
                else if (tail.hit)
                begin
                    found_next  = 1'b1;
                    target_next = IDX_W'(dec_target);
                    chain_next  = tail.pos;
                    state_next  = ST_READ;
                end
                else
                begin
                    chain_next = target_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                cnt_next = cnt_reg + IDX_W'(1);
                if (pass_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = tail.data;
                    out_found_next = found_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            chain_reg     <= '0;
            key_len_reg   <= KEY_LEN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            chain_reg     <= chain_next;
            key_len_reg   <= key_len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg    <= target_next;
        found_reg     <= found_next;
        action_reg    <= action_next;
        sym_reg       <= sym_next;
        out_data_reg  <= out_data_next;
        out_found_reg <= out_found_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_found_reg;

endmodule

// ===== hw/rtl/cka_cell.sv =====
module cka_cell (
    input  logic                     clk,
    input  logic [cka_pkg::IDX_W-1:0] cell_idx,
    input  cka_pkg::cka_wr_t         wr,
    input  cka_pkg::cka_bcast_t      bc,
    input  cka_pkg::cka_rec_t        rec_in,
    output cka_pkg::cka_rec_t        rec_out
);
    import cka_pkg::*;

    logic [SYM_W-1:0] entry_reg;
    logic [SYM_W-1:0] entry_next;
    cka_rec_t         rec_reg;
    cka_rec_t         rec_next;
    logic             in_range;

    assign in_range = SUM_W'(cell_idx) < bc.len;

    always_comb
    begin
        entry_next = entry_reg;
        if (wr.wr_en && (int'(wr.wr_idx) == int'(cell_idx)))
        begin
            entry_next = wr.wr_data;
        end
    end

    // A hit from a lower cell passes through untouched, so the lowest match wins.
    always_comb
    begin
        rec_next = rec_in;
        if (bc.search && !rec_in.hit && in_range && (entry_reg == bc.sym))
        begin
            rec_next.hit = 1'b1;
            rec_next.pos = cell_idx;
        end
        if (bc.readout && (bc.target == cell_idx))
        begin
            rec_next.data = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        rec_reg   <= rec_next;
    end

    assign rec_out = rec_reg;

endmodule

// ===== hw/rtl/cka_checker.sv =====
module cka_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [cka_pkg::ACT_W-1:0]       s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [cka_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic [0:0]                      m_axis_tuser,
    input logic                            cfg_valid,
    input logic                            cfg_ready
);
    import cka_pkg::*;

    // A stalled result beat holds its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // An accepted cipher item closes the input.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready
        && ((s_axis_tuser == ACT_ENC) || (s_axis_tuser == ACT_DEC))
        |=> !s_axis_tready)
        else $error("input reopened during a cipher item");

    // Load and restart items never produce a result.
    a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid
        && ((s_axis_tuser == ACT_LOAD) || (s_axis_tuser == ACT_RESTART))
        |=> !m_axis_tvalid)
        else $error("result appeared after a load or restart");

    // A new result appears exactly as the block returns to idle.
    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result issued while still busy");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind chained_key_alphabet_cipher cka_checker u_cka_checker (.*);
